[sv/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median unit
// Widths, reset defaults and the per-cell control bundle.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int CFG_W          = 7;
    localparam int WINDOW_MAX_DEF = 64;
    localparam int WIN_RESET      = 3;

    // per-cell control from the chain: removal and insertion decisions
    typedef struct packed {
        logic step;     // a sample is taken this cycle
        logic clear;    // empty the window
        logic rm_self;  // removal at or below this cell
        logic rm_dn;    // removal at or below the lower neighbor
        logic gt_self;  // post-removal entry here is above the sample (or empty)
        logic gt_dn;    // same for the lower neighbor (0 below cell 0)
    } cell_ctl_t;

endpackage

[sv/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds one entry; per beat it keeps, shifts down, shifts up or takes the
// new sample, based on its neighbors.
// ----------------------------------------------------------------------------
module swm_cell
    import swm_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctl_t                  ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [AW-1:0]              victim_age,
    input  logic                       dn_valid,
    input  logic [AW-1:0]              dn_age,
    input  logic signed [SAMPLE_W-1:0] dn_value,
    input  logic                       up_valid,
    input  logic [AW-1:0]              up_age,
    input  logic signed [SAMPLE_W-1:0] up_value,
    output logic                       valid,
    output logic [AW-1:0]              age,
    output logic signed [SAMPLE_W-1:0] value,
    output logic                       gt,
    output logic                       hit
);

    logic                       valid_reg, valid_next;
    logic [AW-1:0]              age_reg, age_next;
    logic signed [SAMPLE_W-1:0] value_reg, value_next;

    assign valid = valid_reg;
    assign age   = age_reg;
    assign value = value_reg;
    assign gt    = !valid_reg || (sample < value_reg);
    assign hit   = valid_reg && (age_reg == victim_age);

    always_comb
    begin
        if (!ctl.gt_self)
        begin
            // entry stays below the sample: own slot after removal
            valid_next = ctl.rm_self ? up_valid : valid_reg;
            age_next   = (ctl.rm_self ? up_age : age_reg) + 1'b1;
            value_next = ctl.rm_self ? up_value : value_reg;
        end
        else if (!ctl.gt_dn)
        begin
            valid_next = 1'b1;
            age_next   = '0;
            value_next = sample;
        end
        else
        begin
            // shifted up by the insertion: lower slot after removal
            valid_next = ctl.rm_dn ? valid_reg : dn_valid;
            age_next   = (ctl.rm_dn ? age_reg : dn_age) + 1'b1;
            value_next = ctl.rm_dn ? value_reg : dn_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            age_reg   <= age_next;
            value_reg <= value_next;
        end
    end

endmodule

[sv/swm_chain.sv]
// ----------------------------------------------------------------------------
// swm_chain: row of window cells
// Finds the evicted slot (prefix OR), hands each cell its neighbor entries
// and control, and reads out the entry at the median index.
// ----------------------------------------------------------------------------
module swm_chain
    import swm_pkg::*;
#(
    parameter int N  = WINDOW_MAX_DEF,
    parameter int AW = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       clear,
    input  logic                       remove_en,
    input  logic [AW-1:0]              victim_age,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [AW-1:0]              rd_idx,
    output logic signed [SAMPLE_W-1:0] rd_value
);

    logic [N-1:0]               c_valid;
    logic [AW-1:0]              c_age   [N];
    logic signed [SAMPLE_W-1:0] c_value [N];
    logic [N:0]                 c_gt;
    logic [N-1:0]               c_hit;
    logic [N-1:0]               rm;
    logic [N-1:0]               gt_r;

    // removal at or below slot i: log-depth prefix OR of the victim flags
    always_comb
    begin
        rm = c_hit & {N{remove_en}};
        for (int s = 1; s < N; s = s * 2)
        begin
            rm = rm | (rm << s);
        end
    end

    assign c_gt[N] = 1'b1;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            gt_r[i] = rm[i] ? c_gt[i+1] : c_gt[i];
        end
    end

    generate
        for (genvar i = 0; i < N; i++)
        begin : g_cell
            cell_ctl_t                  ctl;
            logic                       dn_valid, up_valid;
            logic [AW-1:0]              dn_age, up_age;
            logic signed [SAMPLE_W-1:0] dn_value, up_value;

            if (i == 0)
            begin : g_bot
                assign dn_valid   = 1'b0;
                assign dn_age     = '0;
                assign dn_value   = '0;
                assign ctl.rm_dn  = 1'b0;
                assign ctl.gt_dn  = 1'b0;
            end
            else
            begin : g_mid
                assign dn_valid   = c_valid[i-1];
                assign dn_age     = c_age[i-1];
                assign dn_value   = c_value[i-1];
                assign ctl.rm_dn  = rm[i-1];
                assign ctl.gt_dn  = gt_r[i-1];
            end

            if (i == N - 1)
            begin : g_top
                assign up_valid = 1'b0;
                assign up_age   = '0;
                assign up_value = '0;
            end
            else
            begin : g_low
                assign up_valid = c_valid[i+1];
                assign up_age   = c_age[i+1];
                assign up_value = c_value[i+1];
            end

            assign ctl.step    = step;
            assign ctl.clear   = clear;
            assign ctl.rm_self = rm[i];
            assign ctl.gt_self = gt_r[i];

            swm_cell #(
                .AW(AW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .sample     (sample),
                .victim_age (victim_age),
                .dn_valid   (dn_valid),
                .dn_age     (dn_age),
                .dn_value   (dn_value),
                .up_valid   (up_valid),
                .up_age     (up_age),
                .up_value   (up_value),
                .valid      (c_valid[i]),
                .age        (c_age[i]),
                .value      (c_value[i]),
                .gt         (c_gt[i]),
                .hit        (c_hit[i])
            );
        end
    endgenerate

    assign rd_value = c_value[rd_idx];

endmodule

[sv/sliding_window_median_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_unit: streaming lower-median filter
// Keeps the newest window_size samples sorted in a row of cells and emits
// the lower median once the window is full.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : input stream, one signed 32-bit sample per beat in s_tdata.
//   m_* : output stream, one signed 32-bit lower median per beat in m_tdata.
//   cfg_we / cfg_wdata : window size write (0 acts as 1, values above
//         WINDOW_MAX saturate); a write empties the window. Write while idle.
// Each accepted sample is sorted into the cell row in the beat it arrives:
// the oldest entry drops out, the rest shift one slot as needed. The first
// window_size-1 samples after reset or a size write give no output; every
// later sample gives one median, via the read stage and output register.
// Throughput: one sample per cycle unless the output stalls. The median is
// read from the cell row after insertion, into the output register.
// Stall: while m_tready is low the output register holds; one more result
// waits in the read stage, then s_tready drops until the output drains.
// Reset: window empty, size 3 (capped at WINDOW_MAX), no output pending.
// ----------------------------------------------------------------------------
module sliding_window_median_unit
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // sample stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    // median stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,   // [31:0] median
    // window size register
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int WIN_RST = (WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET;

    // window configuration, derived at write time
    logic [CW-1:0] win_reg, win_next;
    logic [AW-1:0] victim_reg, victim_next;
    logic [AW-1:0] med_idx_reg, med_idx_next;
    logic [CW-1:0] win_m1;

    logic [CW-1:0] fill_reg, fill_next;
    logic          full;
    logic          emit;

    // read stage and output register
    logic                       rd_pend_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic signed [SAMPLE_W-1:0] rd_value;
    logic                       advance;
    logic                       accept;

    always_comb
    begin
        if (cfg_wdata == '0)
            win_next = CW'(1);
        else if (int'(cfg_wdata) > WINDOW_MAX)
            win_next = CW'(WINDOW_MAX);
        else
            win_next = CW'(cfg_wdata);
        win_m1       = win_next - 1'b1;
        victim_next  = AW'(win_m1);
        med_idx_next = AW'(win_m1 >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= CW'(WIN_RST);
            victim_reg  <= AW'(WIN_RST - 1);
            med_idx_reg <= AW'((WIN_RST - 1) / 2);
        end
        else if (cfg_we)
        begin
            win_reg     <= win_next;
            victim_reg  <= victim_next;
            med_idx_reg <= med_idx_next;
        end
    end

    // handshake: the read stage moves on when the output register is free
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !rd_pend_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // fill tracking: once full, each beat evicts the oldest entry
    assign full      = (fill_reg == win_reg);
    assign fill_next = full ? fill_reg : fill_reg + 1'b1;
    assign emit      = (fill_next == win_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cfg_we)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    swm_chain #(
        .N  (WINDOW_MAX),
        .AW (AW)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .clear      (cfg_we),
        .remove_en  (full),
        .victim_age (victim_reg),
        .sample     (s_tdata),
        .rd_idx     (med_idx_reg),
        .rd_value   (rd_value)
    );

    // read stage: the cells register the new window at the beat; the median is
    // picked from them and lands in the output register when the stage advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= rd_pend_reg;
            if (accept)
                rd_pend_reg <= emit;
            else if (advance)
                rd_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rd_pend_reg)
            out_data_reg <= rd_value;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[sv/swm_checker.sv]
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the sliding window median unit
// Output hold under stall, backpressure coupling and result latency.
// ----------------------------------------------------------------------------
module swm_checker
    import swm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // input backpressure only with an output beat waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a ready receiver never blocks the input
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // a fresh result traces back to an accepted input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching input beat");

endmodule

bind sliding_window_median_unit swm_checker u_swm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sliding_window_median_checker.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_checker: median stream scoreboard
// Watches the sample, median and window size ports, predicts the lower median
// of the newest window_size samples and compares every median beat in order.
// ----------------------------------------------------------------------------
module sliding_window_median_checker
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [SAMPLE_W-1:0] m_tdata,   // [31:0] median
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata,
    output int                  misses,
    output int                  outstanding
);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    logic [CFG_W-1:0] size_reg = CFG_W'(WIN_RESET);
    sample_t          arrival[$];     // window in arrival order, oldest first
    sample_t          ordered[$];     // same window, ascending
    sample_t          median_due[$];  // medians not yet seen on the output
    int               fault_count = 0;

    // 0 acts as 1, anything above the row length saturates
    function automatic int unsigned span();
        if (size_reg == 0)
            return 1;
        if (size_reg > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return int'(size_reg);
    endfunction

    task automatic take_sample(input sample_t v);
        int unsigned w;
        int          pos;
        bit          gone;
        sample_t     oldest;
        w = span();
        // full window: the oldest sample drops out (any equal copy will do)
        if (arrival.size() == w)
        begin
            oldest = arrival.pop_front();
            gone   = 1'b0;
            for (int i = 0; i < ordered.size() && !gone; i++)
            begin
                if (ordered[i] == oldest)
                begin
                    ordered.delete(i);
                    gone = 1'b1;
                end
            end
        end
        arrival = {arrival, v};
        pos = 0;
        while (pos < ordered.size() && ordered[pos] <= v)
            pos++;
        ordered.insert(pos, v);
        if (ordered.size() == w)
            median_due = {median_due, ordered[(w - 1) / 2]};
    endtask

    task automatic check_median(input sample_t got);
        sample_t want;
        if (median_due.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("median beat with nothing expected: got %0d", got);
        end
        else
        begin
            want = median_due.pop_front();
            if (got !== want)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("median mismatch: expected %0d, got %0d", want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = CFG_W'(WIN_RESET);
            arrival.delete();
            ordered.delete();
            median_due.delete();
        end
        else
        begin
            // a size write empties the window
            if (cfg_we)
            begin
                size_reg = cfg_wdata;
                arrival.delete();
                ordered.delete();
            end
            if (m_tvalid && m_tready)
                check_median(m_tdata);
            if (s_tvalid && s_tready)
                take_sample(s_tdata);
        end
        outstanding <= median_due.size();
        misses      <= fault_count;
    end

endmodule

[tb/sliding_window_median_unit_test.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_unit_test: regression for the median unit
// Drives sample beats through several window sizes (reset size, 1, 0, 2, the
// row length and above it, then random sizes) with random gaps on both
// streams; the checker predicts every median and counts mismatches.
// ----------------------------------------------------------------------------
module sliding_window_median_unit_test;

    import swm_pkg::*;

    localparam int ITEM_TOTAL  = 1250;
    localparam int CALM_ITEMS  = 150;   // tail of the run with no gaps
    localparam int FLUSH_WAIT  = 8;
    localparam int CYCLE_LIMIT = 250000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;    // [31:0] sample
    logic                m_tvalid;
    logic                m_tready;
    logic [SAMPLE_W-1:0] m_tdata;    // [31:0] median
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;

    int                  misses;
    int                  outstanding;
    int                  cycles = 0;
    int                  sent   = 0;
    bit                  steady = 1'b0;  // no gaps on either side while set
    logic [SAMPLE_W-1:0] prev   = '0;

    sliding_window_median_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    sliding_window_median_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .misses      (misses),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost median ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("sliding_window_median_unit regression: fail");
            $finish;
        end
    end

    // Output side: random stall bursts between high stretches, none while steady.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!steady && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Sample mix: full-range words, tight clusters for duplicates, ramps,
    // repeats and values at or next to the two extremes.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] last);
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3, 4:    return SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
            5:       return last + $urandom_range(0, 3);
            6:       return last;
            7:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            8:       return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                 : 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return $urandom() | 32'h8000_0000;
        endcase
    endfunction

    // One sample beat. Called and returns at a rising edge; tready is looked
    // at on the falling edge, where nothing is in motion.
    task automatic push_sample(input logic [SAMPLE_W-1:0] v);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        sent++;
        prev = v;
    endtask

    // Hold off until every predicted median has left the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Size writes go in only once every predicted median has drained; samples
    // that were still filling the window owe no median and the write drops them.
    task automatic set_window(input int unsigned size);
        drain();
        repeat (FLUSH_WAIT) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(size);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned size, input int count);
        set_window(size);
        for (int k = 0; k < count; k++)
        begin
            // one forced hold-off per phase
            if (k == count / 2)
                drain();
            push_sample(pick_sample(prev));
        end
    endtask

    initial
    begin
        int unsigned size;
        int          count;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // reset size (3): extremes, sign boundary, duplicates
        push_sample(32'h8000_0000);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h0000_0001);
        push_sample(32'd5);
        push_sample(32'd5);
        push_sample(32'd5);
        push_sample(32'hFFFF_FFFB);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);

        // window of one: every beat is its own median
        set_window(1);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'hAAAA_AAAA);

        // size zero behaves as one
        set_window(0);
        push_sample(32'h5555_5555);
        push_sample(32'hFFFF_FFFF);

        // even window: lower of the two middle entries
        set_window(2);
        push_sample(32'd4);
        push_sample(32'd4);
        push_sample(32'hFFFF_FFFD);
        push_sample(32'd9);
        push_sample(32'd1);
        push_sample(32'd1);

        // --- random ---
        // full row, then a size past the row that must saturate
        run_phase(WINDOW_MAX_DEF, 150);
        run_phase((1 << CFG_W) - 1, 140);

        while (sent < ITEM_TOTAL - CALM_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 7))
                0, 1, 2, 3, 4: size = $urandom_range(1, 9);
                5, 6:          size = $urandom_range(10, WINDOW_MAX_DEF);
                default:       size = $urandom_range(0, 1) ? 0
                                      : $urandom_range(WINDOW_MAX_DEF + 1, (1 << CFG_W) - 1);
            endcase
            count = $urandom_range(20, 90) + ((size > WINDOW_MAX_DEF) ? 0 : size);
            // keep the total close to the planned item count
            if (count > ITEM_TOTAL - CALM_ITEMS - sent)
                count = ITEM_TOTAL - CALM_ITEMS - sent;
            run_phase(size, count);
        end

        // no gaps for the tail of the run
        steady = 1'b1;
        run_phase($urandom_range(2, 9), CALM_ITEMS);

        drain();
        repeat (20) @(posedge clk);
        if (misses == 0 && outstanding == 0)
            $display("sliding_window_median_unit regression: pass");
        else
            $display("sliding_window_median_unit regression: fail");
        $finish;
    end

endmodule
